FILE: rtl/core/sobel_gradient_magnitude_3x3_top_macros.svh
// assertion macros for the sobel gradient block
// included by the top level; no other dependencies
`ifndef SOBEL_GRADIENT_MAGNITUDE_3X3_TOP_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_3X3_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SGM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define SGM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sgm_pkg.sv
// shared constants and types of the sobel gradient block
// no dependencies
package sgm_pkg;

  localparam int PIX_W        = 8;
  localparam int MAG_W        = 11;
  localparam int GRAD_W       = 11;
  localparam int SUM_W        = 10;
  localparam int SQ_W         = 22;
  localparam int ROOT_STEP_W  = 4;

  localparam int WIDTH_REG_W  = 10;
  localparam int HEIGHT_REG_W = 13;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 10'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT = 13'd4096;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // register select, taken from paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } sgm_root_stat_t;

endpackage

FILE: rtl/core/sgm_pix_if.sv
// pixel input channel: valid/ready handshake with one grey pixel
// depends on sgm_pkg
interface sgm_pix_if;
  logic                      valid;
  logic                      ready;
  logic [sgm_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

FILE: rtl/core/sgm_res_if.sv
// result channel: valid/ready handshake with gradients and magnitude
// depends on sgm_pkg
interface sgm_res_if;
  logic                              valid;
  logic                              ready;
  logic [sgm_pkg::MAG_W-1:0]         magnitude;
  logic signed [sgm_pkg::GRAD_W-1:0] grad_x;
  logic signed [sgm_pkg::GRAD_W-1:0] grad_y;
  logic                              last_of_frame;

  modport source (output valid, output magnitude, output grad_x, output grad_y,
                  output last_of_frame, input ready);
  modport sink   (input valid, input magnitude, input grad_x, input grad_y,
                  input last_of_frame, output ready);
endinterface

FILE: rtl/core/sgm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sgm_sqrt.sv
// iterative floor square root, two radicand bits per cycle
// depends on sgm_pkg
module sgm_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sgm_pkg::SQ_W-1:0]    radicand_i,
  output logic [sgm_pkg::MAG_W-1:0]   root_o,
  output sgm_pkg::sgm_root_stat_t     stat_o
);

  localparam int RW = sgm_pkg::MAG_W;
  localparam int SW = sgm_pkg::ROOT_STEP_W;

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [SW-1:0]              cnt_q, cnt_d;
  logic [sgm_pkg::SQ_W-1:0]   rad_q, rad_d;
  logic [RW+1:0]              rem_q, rem_d;
  logic [RW-1:0]              root_q, root_d;
  logic [RW+3:0]              shifted;
  logic [RW+3:0]              trial;
  logic [RW+3:0]              diff;

  assign shifted = {rem_q, rad_q[sgm_pkg::SQ_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign diff    = shifted - trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[sgm_pkg::SQ_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_d  = diff[RW+1:0];
        root_d = {root_q[RW-2:0], 1'b1};
      end else begin
        rem_d  = shifted[RW+1:0];
        root_d = {root_q[RW-2:0], 1'b0};
      end
      cnt_d = cnt_q + SW'(1);
      if (cnt_q == SW'(RW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o      = root_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: rtl/core/sobel_gradient_magnitude_3x3_top.sv
// sobel 3x3 gradient and magnitude over a zero-bordered raster pixel stream
// depends on sgm_pkg, sgm_pix_if, sgm_res_if, sgm_ram, sgm_sqrt and the macro header
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+-------------------------------------------
//   pix_i    | in  | valid/ready       | pixel[7:0]
//   res_o    | out | valid/ready       | magnitude[10:0] grad_x/grad_y s[10:0] last
//   apb      | in  | psel/penable      | paddr[2:0] pwdata/prdata[31:0], pready = 1
//
// border pixel (no result): line-store fetch then take
// interior pixel: fetch, take, square, the 11-step square root unit, then hand-off
// reset resets counters, window, size registers and control, not the line stores
// a waiting result word holds the next interior result, and pixel input with it
`include "sobel_gradient_magnitude_3x3_top_macros.svh"

module sobel_gradient_magnitude_3x3_top #(
  parameter int MAX_PADDED_WIDTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sgm_pix_if.sink                            pix_i,
  sgm_res_if.source                          res_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sgm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [sgm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [sgm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  // column counter and line-store address width
  localparam int CW   = $clog2(MAX_PADDED_WIDTH);
  // padded-width width: holds image_width + 2 and the maximum
  localparam int PWW  = ($clog2(MAX_PADDED_WIDTH + 1) > 11) ?
                        $clog2(MAX_PADDED_WIDTH + 1) : 11;
  localparam int HW   = sgm_pkg::HEIGHT_REG_W;
  localparam int PW8  = sgm_pkg::PIX_W;
  localparam int SUMW = sgm_pkg::SUM_W;
  localparam int GW   = sgm_pkg::GRAD_W;

  // sequencer states
  localparam logic [2:0] S_FETCH  = 3'd0;  // read line stores at current column
  localparam logic [2:0] S_TAKE   = 3'd1;  // wait for a pixel
  localparam logic [2:0] S_SQUARE = 3'd2;  // square gradients, start root
  localparam logic [2:0] S_ROOT   = 3'd3;  // root unit busy
  localparam logic [2:0] S_DONE   = 3'd4;  // hand result to the output register

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [sgm_pkg::WIDTH_REG_W-1:0] width_q;
  logic [HW-1:0]                   height_q;
  logic                            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sgm_pkg::WIDTH_RESET;
      height_q <= sgm_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        sgm_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[sgm_pkg::WIDTH_REG_W-1:0];
        sgm_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sgm_pkg::REG_IMAGE_WIDTH:  prdata = sgm_pkg::APB_DATA_W'(width_q);
      sgm_pkg::REG_IMAGE_HEIGHT: prdata = sgm_pkg::APB_DATA_W'(height_q);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // padded frame size and normalized counters
  // ---------------------------------------------------------------------------
  logic [PWW-1:0] pw_raw, pw;
  logic [HW-1:0]  h_sat, ph;
  logic [CW-1:0]  col_q, col_d, col_eff;
  logic [HW-1:0]  row_q, row_d, row_eff, row_inc;
  logic [PWW-1:0] col_inc;

  assign pw_raw = PWW'(width_q) + PWW'(2);
  // padded width saturates at the line-store depth
  assign pw     = (pw_raw > PWW'(MAX_PADDED_WIDTH)) ? PWW'(MAX_PADDED_WIDTH) : pw_raw;
  assign h_sat  = (height_q > sgm_pkg::HEIGHT_LIMIT) ? sgm_pkg::HEIGHT_LIMIT : height_q;
  assign ph     = h_sat + HW'(2);

  // a counter left beyond a shrunk frame size wraps to zero
  assign col_eff = (PWW'(col_q) >= pw) ? '0 : col_q;
  assign row_eff = (row_q >= ph) ? '0 : row_q;
  assign col_inc = PWW'(col_eff) + PWW'(1);
  assign row_inc = row_eff + HW'(1);

  always_comb begin
    if (col_inc >= pw) begin
      col_d = '0;
      row_d = (row_inc >= ph) ? '0 : row_inc;
    end else begin
      col_d = col_inc[CW-1:0];
      row_d = row_eff;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer and handshake
  // ---------------------------------------------------------------------------
  logic [2:0]     state_q, state_d;
  logic [CW-1:0]  rd_addr_q;
  logic           in_fire;
  logic           out_fire;
  logic           interior;
  logic           last_pix;
  logic           addr_ok;
  logic           load_out;
  sgm_pkg::sgm_root_stat_t root_stat;

  // read data is only good for the column it was fetched for
  assign addr_ok   = (rd_addr_q == col_eff);
  assign pix_i.ready = (state_q == S_TAKE) && addr_ok;
  assign in_fire   = pix_i.valid && pix_i.ready;
  assign interior  = (row_eff >= HW'(2)) && (col_eff >= CW'(2));
  assign last_pix  = (row_inc == ph) && (col_inc == pw);

  logic out_valid_q;
  assign out_fire = out_valid_q && res_o.ready;
  assign load_out = (state_q == S_DONE) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_FETCH: state_d = S_TAKE;
      S_TAKE: begin
        if (!addr_ok) begin
          state_d = S_FETCH;
        end else if (in_fire) begin
          state_d = interior ? S_SQUARE : S_FETCH;
        end
      end
      S_SQUARE: state_d = S_ROOT;
      S_ROOT: begin
        if (root_stat.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_FETCH;
        end
      end
      default: state_d = S_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_FETCH;
      rd_addr_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FETCH) begin
        rd_addr_q <= col_eff;
      end
      if (in_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // line stores: second_prev holds two rows up, prev one row up
  // ---------------------------------------------------------------------------
  logic [PW8-1:0] top_pix, mid_pix, bot_pix;

  assign bot_pix = pix_i.pixel;

  sgm_ram #(
    .WIDTH (PW8),
    .DEPTH (MAX_PADDED_WIDTH)
  ) u_second_prev_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (col_eff),
    .wdata_i (mid_pix),
    .re_i    (state_q == S_FETCH),
    .raddr_i (col_eff),
    .rdata_o (top_pix)
  );

  sgm_ram #(
    .WIDTH (PW8),
    .DEPTH (MAX_PADDED_WIDTH)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (col_eff),
    .wdata_i (bot_pix),
    .re_i    (state_q == S_FETCH),
    .raddr_i (col_eff),
    .rdata_o (mid_pix)
  );

  // ---------------------------------------------------------------------------
  // 3x3 window: two older columns in registers, newest from pixel input and stores
  // ---------------------------------------------------------------------------
  logic [PW8-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (in_fire) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_pix;
      win_q[4] <= mid_pix;
      win_q[5] <= bot_pix;
    end
  end

  // 1-2-1 weighted sums, each at most 1020
  logic [SUMW-1:0] sum_left, sum_right, sum_top, sum_bot;
  logic signed [GW-1:0] gx, gy;

  assign sum_left  = SUMW'(win_q[0]) + {1'b0, win_q[1], 1'b0} + SUMW'(win_q[2]);
  assign sum_right = SUMW'(top_pix) + {1'b0, mid_pix, 1'b0} + SUMW'(bot_pix);
  assign sum_top   = SUMW'(win_q[0]) + {1'b0, win_q[3], 1'b0} + SUMW'(top_pix);
  assign sum_bot   = SUMW'(win_q[2]) + {1'b0, win_q[5], 1'b0} + SUMW'(bot_pix);
  assign gx = $signed({1'b0, sum_left}) - $signed({1'b0, sum_right});
  assign gy = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bot});

  // gradients of the item in flight
  logic signed [GW-1:0] gx_q, gy_q;
  logic                 last_q;

  always_ff @(posedge clk_i) begin
    if (in_fire && interior) begin
      gx_q   <= gx;
      gy_q   <= gy;
      last_q <= last_pix;
    end
  end

  // ---------------------------------------------------------------------------
  // squares feed the root unit, which registers the sum on start
  // ---------------------------------------------------------------------------
  logic signed [2*GW-1:0]     gx_sq, gy_sq;
  logic [sgm_pkg::SQ_W-1:0]   sq_sum;
  logic [sgm_pkg::MAG_W-1:0]  root;

  assign gx_sq  = gx_q * gx_q;
  assign gy_sq  = gy_q * gy_q;
  assign sq_sum = sgm_pkg::SQ_W'($unsigned(gx_sq)) + sgm_pkg::SQ_W'($unsigned(gy_sq));

  sgm_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_SQUARE),
    .radicand_i (sq_sum),
    .root_o     (root),
    .stat_o     (root_stat)
  );

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic [sgm_pkg::MAG_W-1:0] mag_out_q;
  logic signed [GW-1:0]      gx_out_q, gy_out_q;
  logic                      last_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      mag_out_q  <= root;
      gx_out_q   <= gx_q;
      gy_out_q   <= gy_q;
      last_out_q <= last_q;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.magnitude     = mag_out_q;
  assign res_o.grad_x        = gx_out_q;
  assign res_o.grad_y        = gy_out_q;
  assign res_o.last_of_frame = last_out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  logic done_stall;
  logic at_origin;

  assign done_stall = (state_q == S_DONE) && out_valid_q && !res_o.ready;
  assign at_origin  = (col_q == '0) && (row_q == '0);

  // the root unit only finishes while the sequencer waits for it
  `SGM_ASSERT_NOW(a_root_done_in_root, clk_i, rst_ni, root_stat.done, state_q == S_ROOT, "stray done")
  // a finished result is held while the output word is still pending
  `SGM_ASSERT_NEXT(a_done_holds, clk_i, rst_ni, done_stall, state_q == S_DONE, "result dropped")
  // the last word of a frame leaves both counters back at the frame start
  `SGM_ASSERT_NOW(a_last_wraps, clk_i, rst_ni, load_out && last_q, at_origin, "no frame wrap")

endmodule

FILE: bench/tb_sobel_gradient_magnitude_3x3_top.sv
// testbench for the sobel 3x3 gradient block: pixel frames in, gradient words checked
// depends on sgm_pkg, sgm_pix_if, sgm_res_if and sobel_gradient_magnitude_3x3_top
// self-checking, with its own line-store predictor and an apb register driver
module tb_sobel_gradient_magnitude_3x3_top;

  localparam int PAD_WIDTH_MAX  = 1024;
  localparam int QUIET_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving on either side

  // one result word as the block should send it
  typedef struct packed {
    logic [sgm_pkg::MAG_W-1:0]         magnitude;
    logic signed [sgm_pkg::GRAD_W-1:0] grad_x;
    logic signed [sgm_pkg::GRAD_W-1:0] grad_y;
    logic                              last_of_frame;
  } grad_word_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // channels, driven from testbench variables so that they are known from time zero
  sgm_pix_if pix_bus ();
  sgm_res_if res_bus ();

  logic                      pix_valid = 1'b0;
  logic [sgm_pkg::PIX_W-1:0] pix_data  = '0;
  logic                      res_ready = 1'b0;

  assign pix_bus.valid = pix_valid;
  assign pix_bus.pixel = pix_data;
  assign res_bus.ready = res_ready;

  // apb register port
  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [sgm_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [sgm_pkg::APB_DATA_W-1:0] pwdata  = '0;
  logic [sgm_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  sobel_gradient_magnitude_3x3_top #(
    .MAX_PADDED_WIDTH(PAD_WIDTH_MAX)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_bus),
    .res_o  (res_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // predictor state: registers, two line stores, 3x2 window, raster position
  logic [sgm_pkg::WIDTH_REG_W-1:0]  cfg_width  = sgm_pkg::WIDTH_RESET;
  logic [sgm_pkg::HEIGHT_REG_W-1:0] cfg_height = sgm_pkg::HEIGHT_RESET;
  logic [sgm_pkg::PIX_W-1:0]        line_prev  [PAD_WIDTH_MAX];
  logic [sgm_pkg::PIX_W-1:0]        line_prev2 [PAD_WIDTH_MAX];
  logic [sgm_pkg::PIX_W-1:0]        win [6];
  int unsigned                      col_pos = 0;
  int unsigned                      row_pos = 0;

  // traffic bookkeeping
  logic [sgm_pkg::PIX_W-1:0] pixel_feed[$];
  grad_word_t       pending_grads[$];
  int unsigned      items_queued  = 0;
  int unsigned      items_taken   = 0;
  int unsigned      results_seen  = 0;
  int unsigned      frame_ends    = 0;
  int unsigned      reg_writes    = 0;
  int unsigned      errors        = 0;
  logic             pix_took      = 1'b0;
  int unsigned      stall_cycles  = 0;

  // idling knobs, in percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // receiver hold-off requests, served by the receiver process
  int unsigned hold_asked  = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;

  initial begin
    for (int i = 0; i < PAD_WIDTH_MAX; i++) begin
      line_prev[i]  = '0;
      line_prev2[i] = '0;
    end
    for (int i = 0; i < 6; i++) begin
      win[i] = '0;
    end
  end

  task automatic flag_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // padded frame size, with the block's saturation of oversized registers
  function automatic int unsigned padded_cols(input int unsigned w);
    return (w + 2 > PAD_WIDTH_MAX) ? PAD_WIDTH_MAX : w + 2;
  endfunction

  function automatic int unsigned padded_rows(input int unsigned h);
    return ((h > sgm_pkg::HEIGHT_LIMIT) ? sgm_pkg::HEIGHT_LIMIT : h) + 2;
  endfunction

  // advance the predictor by one pixel word; returns 1 when a result word is due
  function automatic bit sobel_predict(input logic [sgm_pkg::PIX_W-1:0] px,
                                       output grad_word_t want);
    int unsigned pw, ph, col, row, sq, root, trial;
    int          top, mid, bot, t0, m0, b0, t1, b1, gx, gy, b;
    bit          hit;
    pw = padded_cols(cfg_width);
    ph = padded_rows(cfg_height);
    // a shrunk register wraps the counters on the next pixel
    if (col_pos >= pw) col_pos = 0;
    if (row_pos >= ph) row_pos = 0;
    col = col_pos;
    row = row_pos;
    top = line_prev2[col];
    mid = line_prev[col];
    bot = px;
    t0 = win[0];
    m0 = win[1];
    b0 = win[2];
    t1 = win[3];
    b1 = win[5];
    hit = (row >= 2) && (col >= 2);
    want = '0;
    if (hit) begin
      gx = (t0 + 2 * m0 + b0) - (top + 2 * mid + bot);
      gy = (t0 + 2 * t1 + top) - (b0 + 2 * b1 + bot);
      sq = gx * gx + gy * gy;
      // bit-by-bit floor square root, 11 result bits
      root = 0;
      for (b = sgm_pkg::MAG_W - 1; b >= 0; b--) begin
        trial = root | (1 << b);
        if (trial * trial <= sq) root = trial;
      end
      want.magnitude     = root[sgm_pkg::MAG_W-1:0];
      want.grad_x        = gx[sgm_pkg::GRAD_W-1:0];
      want.grad_y        = gy[sgm_pkg::GRAD_W-1:0];
      want.last_of_frame = (row + 1 == ph) && (col + 1 == pw);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top[sgm_pkg::PIX_W-1:0];
    win[4] = mid[sgm_pkg::PIX_W-1:0];
    win[5] = px;
    line_prev2[col] = mid[sgm_pkg::PIX_W-1:0];
    line_prev[col]  = px;
    col_pos = col + 1;
    if (col_pos >= pw) begin
      col_pos = 0;
      row_pos = row + 1;
      if (row_pos >= ph) row_pos = 0;
    end
    return hit;
  endfunction

  // pixel driver: holds a word until taken, may idle between words
  always @(negedge clk) begin
    if (!pix_valid || pix_took) begin
      if (rst_n && pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        pix_valid <= 1'b1;
        pix_data  <= pixel_feed.pop_front();
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_left != 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      res_ready   <= 1'b0;
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES - 1;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on every taken pixel word, check every taken result word
  always @(posedge clk) begin
    grad_word_t want, got;
    pix_took <= pix_bus.valid && pix_bus.ready;
    if (pix_bus.valid && pix_bus.ready) begin
      items_taken++;
      if (sobel_predict(pix_bus.pixel, want)) pending_grads.push_back(want);
    end
    if (res_bus.valid && res_bus.ready) begin
      results_seen++;
      got.magnitude     = res_bus.magnitude;
      got.grad_x        = res_bus.grad_x;
      got.grad_y        = res_bus.grad_y;
      got.last_of_frame = res_bus.last_of_frame;
      if (pending_grads.size() == 0) begin
        flag_mismatch("result word with no pixel waiting for one");
      end else begin
        want = pending_grads.pop_front();
        if (want.last_of_frame) frame_ends++;
        if (got.magnitude !== want.magnitude)
          flag_mismatch($sformatf("word %0d magnitude %0d, want %0d",
                                  results_seen, got.magnitude, want.magnitude));
        if (got.grad_x !== want.grad_x)
          flag_mismatch($sformatf("word %0d grad_x %0d, want %0d",
                                  results_seen, got.grad_x, want.grad_x));
        if (got.grad_y !== want.grad_y)
          flag_mismatch($sformatf("word %0d grad_y %0d, want %0d",
                                  results_seen, got.grad_y, want.grad_y));
        if (got.last_of_frame !== want.last_of_frame)
          flag_mismatch($sformatf("word %0d last_of_frame %b, want %b",
                                  results_seen, got.last_of_frame, want.last_of_frame));
      end
    end
  end

  // watchdog: ends a hung run
  always @(posedge clk) begin
    if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results still due",
               stall_cycles, pending_grads.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // apb write: setup cycle, then access until pready
  task automatic apb_write(input logic [sgm_pkg::APB_ADDR_W-1:0] addr,
                           input logic [sgm_pkg::APB_DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    reg_writes++;
  endtask

  task automatic apb_read(input logic [sgm_pkg::APB_ADDR_W-1:0] addr,
                          output logic [sgm_pkg::APB_DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    data = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // write both size registers, mirror them in the predictor, read them back
  task automatic set_frame_size(input int unsigned w, input int unsigned h);
    logic [sgm_pkg::APB_DATA_W-1:0] rd;
    apb_write({sgm_pkg::REG_IMAGE_WIDTH, 2'b00}, sgm_pkg::APB_DATA_W'(w));
    apb_write({sgm_pkg::REG_IMAGE_HEIGHT, 2'b00}, sgm_pkg::APB_DATA_W'(h));
    cfg_width  = w[sgm_pkg::WIDTH_REG_W-1:0];
    cfg_height = h[sgm_pkg::HEIGHT_REG_W-1:0];
    apb_read({sgm_pkg::REG_IMAGE_WIDTH, 2'b00}, rd);
    if (rd[sgm_pkg::WIDTH_REG_W-1:0] !== cfg_width)
      flag_mismatch($sformatf("image_width reads %0d, written %0d", rd, w));
    apb_read({sgm_pkg::REG_IMAGE_HEIGHT, 2'b00}, rd);
    if (rd[sgm_pkg::HEIGHT_REG_W-1:0] !== cfg_height)
      flag_mismatch($sformatf("image_height reads %0d, written %0d", rd, h));
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // waits until every pixel word is taken and every result word checked, then a quiet spell
  task automatic wait_all_results();
    while (items_taken != items_queued || pending_grads.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  function automatic logic [sgm_pkg::PIX_W-1:0] any_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return sgm_pkg::PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_pixel(input logic [sgm_pkg::PIX_W-1:0] px);
    pixel_feed.push_back(px);
    items_queued++;
  endtask

  // queue a raster span of a padded frame; clean frames keep the zero border
  task automatic push_pixels(input int unsigned w, input int unsigned h,
                             input int unsigned first, input int unsigned count,
                             input bit noisy);
    int unsigned pw, ph, idx, r, c;
    bit          on_border;
    pw = padded_cols(w);
    ph = padded_rows(h);
    for (idx = first; idx < first + count; idx++) begin
      r = idx / pw;
      c = idx % pw;
      on_border = (r == 0) || (r == ph - 1) || (c == 0) || (c == pw - 1);
      queue_pixel((on_border && !noisy) ? '0 : any_pixel());
    end
  endtask

  task automatic push_frame(input bit noisy);
    push_pixels(cfg_width, cfg_height, 0,
                padded_cols(cfg_width) * padded_rows(cfg_height), noisy);
  endtask

  // after a mid-frame register change: random words up to the end of the frame
  task automatic finish_frame();
    int unsigned pw, ph, col, row, left;
    pw   = padded_cols(cfg_width);
    ph   = padded_rows(cfg_height);
    col  = (col_pos >= pw) ? 0 : col_pos;
    row  = (row_pos >= ph) ? 0 : row_pos;
    left = (row == 0 && col == 0) ? 0 : (ph - row) * pw - col;
    push_pixels(cfg_width, cfg_height, row * pw + col, left, 1'b1);
  endtask

  // random frames of mostly small sizes; sizes change only between frames
  task automatic random_frames(input int unsigned n_items);
    int unsigned done_items, w, h, pick;
    done_items = 0;
    while (done_items < n_items) begin
      if (done_items == 0 || $urandom_range(2) == 0) begin
        pick = $urandom_range(19);
        w = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(40, 20) : $urandom_range(10, 1);
        h = ($urandom_range(19) == 0) ? 0 : $urandom_range(6, 1);
        wait_all_results();
        set_frame_size(w, h);
      end
      push_frame($urandom_range(4) == 0);
      done_items += padded_cols(cfg_width) * padded_rows(cfg_height);
    end
  endtask

  // stimulus sequence
  initial begin
    int unsigned r, c;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // sender idles lightly, receiver stalls most of the time
    set_idling(9, 88);

    // directed: single-interior frames hitting the gradient extremes
    set_frame_size(1, 1);
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) queue_pixel((c == 0) ? '1 : '0);           // grad_x at top
    end
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) queue_pixel((r == 2) ? '1 : '0);           // grad_y at bottom
    end
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) queue_pixel((r == 0 || c == 0) ? '1 : '0); // both, diagonal
    end
    wait_all_results();

    random_frames(80);

    // width shrunk in the middle of a row: column wraps, row is kept
    wait_all_results();
    set_frame_size(8, 5);
    push_pixels(8, 5, 0, 45, 1'b0);
    wait_all_results();
    set_frame_size(3, 5);
    finish_frame();

    // now the sender idles most and the receiver rarely
    set_idling(88, 9);
    random_frames(80);

    // oversized height, cut short by a smaller height that wraps the row counter
    wait_all_results();
    set_frame_size(1, 8191);
    push_pixels(1, 8191, 0, 36, 1'b0);
    wait_all_results();
    set_frame_size(1, 5);
    finish_frame();
    push_frame(1'b0);

    // height shrunk mid-frame while the current row is still inside the new frame
    wait_all_results();
    set_frame_size(4, 6);
    push_pixels(4, 6, 0, 20, 1'b0);
    wait_all_results();
    set_frame_size(4, 3);
    finish_frame();

    // no idling from here on
    set_idling(0, 0);
    random_frames(60);

    // receiver held off while the sender keeps offering: block fills and stalls input
    wait_all_results();
    set_frame_size(6, 4);
    repeat (3) push_frame(1'b0);
    hold_asked++;

    // widest row, padded width saturates at the line-store depth so the row ends at 1024,
    // then a narrow frame takes over from the second row
    wait_all_results();
    set_frame_size(1023, 1);
    push_pixels(1023, 1, 0, PAD_WIDTH_MAX, 1'b1);
    wait_all_results();
    set_frame_size(3, 1);
    finish_frame();
    hold_asked++;

    // empty interior, then a small frame to close
    wait_all_results();
    set_frame_size(0, 0);
    push_frame(1'b1);
    wait_all_results();
    set_frame_size(2, 2);
    push_frame(1'b0);
    wait_all_results();

    $display("covered %0d pixel words, %0d result words, %0d frame ends, %0d register writes",
             items_taken, results_seen, frame_ends, reg_writes);
    $display("sizes from empty to 1023 columns and 8191 rows, mid-frame changes, %0d-cycle holds",
             HOLD_CYCLES);
    if (errors == 0 && pending_grads.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
